// ===== rtl/swfs_pkg.sv =====
// Package for the stop-and-wait file sender: phase and action codes, event
// codes, and the state, configuration and result structs shared by the RTL.
// No dependencies.
`default_nettype none

package swfs_pkg;

   localparam int unsigned FileSizeWidth   = 32;
   localparam int unsigned TimeoutWidth    = 16;
   localparam int unsigned RetryWidth      = 8;
   localparam int unsigned TimeWidth       = 32;
   localparam int unsigned LenWidth        = 10;
   localparam int unsigned CountWidth      = 32;
   localparam int unsigned CsrIndexWidth   = 2;
   localparam int unsigned CsrDataWidth    = 32;

   // Largest payload of one packet; reads above it are clipped.
   localparam logic [15:0] PayloadMax = 16'd1008;

   localparam logic [FileSizeWidth-1:0] FileSizeReset   = '0;
   localparam logic [TimeoutWidth-1:0]  TimeoutReset    = 16'd1200;
   localparam logic [RetryWidth-1:0]    MaxRetriesReset = 8'd5;
   localparam logic [RetryWidth-1:0]    RetrySaturate   = '1;

   typedef enum logic [1:0] {
      PH_START    = 2'd0,
      PH_WORKING  = 2'd1,
      PH_COMPLETE = 2'd2,
      PH_ERROR    = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_SEND   = 3'd1,
      ACT_RESEND = 3'd2,
      ACT_DONE   = 3'd3,
      ACT_FAIL   = 3'd4
   } action_type;

   // Event codes carried on req_op; the fourth code is ignored.
   localparam logic [1:0] OP_POLL   = 2'd0;
   localparam logic [1:0] OP_NEXT   = 2'd1;
   localparam logic [1:0] OP_REPEAT = 2'd2;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_FILE_SIZE   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TIMEOUT     = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_RETRIES = 2'd2;

   typedef struct packed {
      logic [FileSizeWidth-1:0] file_size;
      logic [TimeoutWidth-1:0]  timeout_ms;
      logic [RetryWidth-1:0]    max_retries;
   } cfg_type;

   typedef struct packed {
      phase_type             phase;
      logic [CountWidth-1:0] packet_count;
      logic [CountWidth-1:0] byte_count;
      logic [RetryWidth-1:0] retry_count;
      logic [TimeWidth-1:0]  last_send_time;
      logic [LenWidth-1:0]   chunk_len;
   } state_type;

   typedef struct packed {
      action_type            action;
      logic [CountWidth-1:0] packet_number;
      logic [LenWidth-1:0]   payload_len;
      logic [CountWidth-1:0] bytes_total;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/stop_and_wait_file_sender_unit.sv =====
// Stop-and-wait file sender, top level: config registers, sender state and
// the result register. Uses swfs_pkg and swfs_step.
// Results are registered: on rsp_* the cycle after the event transfer.
// One event per cycle when not stalled; the state regs close the only loop.
// req_ready stays high while the result register is empty or being drained.
// Reset (synchronous): phase start, counters clear, config to its defaults.
`default_nettype none

module stop_and_wait_file_sender_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [9:0]  req_read_len,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_action,
   output logic [31:0]      rsp_packet_number,
   output logic [9:0]       rsp_payload_len,
   output logic [31:0]      rsp_bytes_total,
   input  wire logic        csr_we,
   input  wire logic [swfs_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [swfs_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import swfs_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff, state_in;
   result_type res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_transfer;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_transfer = req_valid && req_ready;

   swfs_step u_step (
      .cfg      (cfg_ff),
      .cur      (state_ff),
      .op       (req_op),
      .now_ms   (req_now_ms),
      .read_len (req_read_len),
      .nxt      (state_in),
      .res      (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.file_size   <= FileSizeReset;
         cfg_ff.timeout_ms  <= TimeoutReset;
         cfg_ff.max_retries <= MaxRetriesReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FILE_SIZE:   cfg_ff.file_size   <= csr_wdata[FileSizeWidth-1:0];
            CSR_TIMEOUT:     cfg_ff.timeout_ms  <= csr_wdata[TimeoutWidth-1:0];
            CSR_MAX_RETRIES: cfg_ff.max_retries <= csr_wdata[RetryWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_START;
         state_ff.packet_count   <= '0;
         state_ff.byte_count     <= '0;
         state_ff.retry_count    <= '0;
         state_ff.last_send_time <= '0;
         state_ff.chunk_len      <= '0;
      end else if (req_transfer) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_transfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = res_ff.action;
   assign rsp_packet_number = res_ff.packet_number;
   assign rsp_payload_len   = res_ff.payload_len;
   assign rsp_bytes_total   = res_ff.bytes_total;

endmodule

`default_nettype wire

// ===== rtl/swfs_step.sv =====
// One event step of the sender: next state and the result for one event.
// Purely combinational; depends on swfs_pkg.
`default_nettype none

module swfs_step (
   input  wire swfs_pkg::cfg_type    cfg,
   input  wire swfs_pkg::state_type  cur,
   input  wire logic [1:0]           op,
   input  wire logic [31:0]          now_ms,
   input  wire logic [9:0]           read_len,
   output swfs_pkg::state_type       nxt,
   output swfs_pkg::result_type      res
);
   import swfs_pkg::*;

   logic [LenWidth-1:0]   len;
   logic [CountWidth-1:0] sum_bytes;
   logic [RetryWidth-1:0] retry_bump;
   logic                  retry_fail;
   logic [TimeWidth-1:0]  elapsed;
   logic                  timed_out;
   action_type            act;

   always_comb begin
      if ({6'd0, read_len} > PayloadMax) begin
         len = PayloadMax[LenWidth-1:0];
      end else begin
         len = read_len;
      end
   end

   assign sum_bytes  = cur.byte_count + {{(CountWidth-LenWidth){1'b0}}, len};
   assign retry_bump = (cur.retry_count == RetrySaturate) ? cur.retry_count
                                                          : cur.retry_count + RetryWidth'(1);
   assign retry_fail = retry_bump >= cfg.max_retries;
   assign elapsed    = now_ms - cur.last_send_time;
   assign timed_out  = elapsed > {{(TimeWidth-TimeoutWidth){1'b0}}, cfg.timeout_ms};

   always_comb begin
      nxt = cur;
      act = ACT_NONE;
      unique case (cur.phase)
         PH_START: begin
            if (op == OP_POLL) begin
               nxt.packet_count = '0;
               nxt.chunk_len    = len;
               nxt.byte_count   = {{(CountWidth-LenWidth){1'b0}}, len};
               if (len != '0) begin
                  nxt.last_send_time = now_ms;
                  nxt.phase          = PH_WORKING;
                  nxt.retry_count    = '0;
                  act                = ACT_SEND;
               end else begin
                  nxt.phase = PH_ERROR;
                  act       = ACT_FAIL;
               end
            end
         end
         PH_WORKING: begin
            // a retry is a timed-out poll or an explicit repeat request
            if ((op == OP_POLL && timed_out) || op == OP_REPEAT) begin
               nxt.retry_count = retry_bump;
               if (retry_fail) begin
                  nxt.phase = PH_ERROR;
                  act       = ACT_FAIL;
               end else begin
                  nxt.last_send_time = now_ms;
                  act                = ACT_RESEND;
               end
            end else if (op == OP_NEXT) begin
               nxt.retry_count  = '0;
               nxt.packet_count = cur.packet_count + CountWidth'(1);
               nxt.chunk_len    = len;
               nxt.byte_count   = sum_bytes;
               if (len != '0) begin
                  nxt.last_send_time = now_ms;
                  act                = ACT_SEND;
               end else if (sum_bytes == cfg.file_size) begin
                  nxt.phase = PH_COMPLETE;
                  act       = ACT_DONE;
               end else begin
                  nxt.phase = PH_ERROR;
                  act       = ACT_FAIL;
               end
            end
         end
         default: begin
            // complete and error hold until reset
         end
      endcase
   end

   always_comb begin
      res.action        = act;
      res.packet_number = nxt.packet_count;
      res.payload_len   = (act == ACT_SEND || act == ACT_RESEND) ? nxt.chunk_len : '0;
      res.bytes_total   = nxt.byte_count;
   end

endmodule

`default_nettype wire

// ===== rtl/swfs_checker.sv =====
// Port-level checks for the stop-and-wait file sender, bound to the top level.
// Depends on swfs_pkg and stop_and_wait_file_sender_unit.
`default_nettype none

module swfs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_action,
   input wire logic [9:0]  rsp_payload_len,
   input wire logic [31:0] rsp_packet_number
);
   import swfs_pkg::*;

   // a held result keeps its action, packet number and length until the transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_packet_number) && $stable(rsp_payload_len))
      else $error("result changed while stalled");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow the result register");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("event transfer produced no result");

   a_len_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != ACT_SEND && rsp_action != ACT_RESEND
         |-> rsp_payload_len == '0)
      else $error("payload length on a non-send action");

   a_send_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_SEND |-> rsp_payload_len != '0)
      else $error("new chunk sent with zero length");

endmodule

bind stop_and_wait_file_sender_unit swfs_checker u_swfs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_action        (rsp_action),
   .rsp_payload_len   (rsp_payload_len),
   .rsp_packet_number (rsp_packet_number)
);

`default_nettype wire
